// ----- design/msgp_pkg.sv -----
// Shared types, constants and microcode ROM of the message pacer.
`timescale 1ns / 1ps
`default_nettype none

package msgp_pkg;

	localparam int RATE_W = 20;
	localparam int RAMP_W = 16;
	localparam int TIME_W = 32;
	localparam int WAIT_W = 20;
	localparam int CFG_IDX_W = 1;
	localparam int PC_W = 4;
	localparam int DIV_STEPS = 20;
	localparam int DIV_CNT_W = 5;
	localparam int DIV_REM_W = 21;
	localparam int PROD_W = 52;

	localparam logic [WAIT_W-1:0] USEC_PER_SEC = 20'd1000000;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SECONDS = 1'b1;

	localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [PC_W-1:0] STEP_DISPATCH = 4'd1;
	localparam logic [PC_W-1:0] STEP_RAMP = 4'd2;
	localparam logic [PC_W-1:0] STEP_MUL = 4'd3;
	localparam logic [PC_W-1:0] STEP_DIV_RAMP = 4'd4;
	localparam logic [PC_W-1:0] STEP_WAIT_RAMP = 4'd5;
	localparam logic [PC_W-1:0] STEP_DIV_GAP = 4'd6;
	localparam logic [PC_W-1:0] STEP_WAIT_GAP = 4'd7;
	localparam logic [PC_W-1:0] STEP_TO_DECIDE = 4'd8;
	localparam logic [PC_W-1:0] STEP_DIV_STEADY = 4'd9;
	localparam logic [PC_W-1:0] STEP_WAIT_STEADY = 4'd10;
	localparam logic [PC_W-1:0] STEP_DECIDE = 4'd11;
	localparam logic [PC_W-1:0] STEP_EMIT = 4'd12;
	localparam logic [PC_W-1:0] STEP_EMIT_DONE = 4'd13;
	localparam logic [PC_W-1:0] STEP_MEASURED = 4'd14;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_ACCEPT,
		DP_RAMP,
		DP_MUL,
		DP_DIV_RAMP,
		DP_DIV_GAP,
		DP_DIV_STEADY,
		DP_DECIDE,
		DP_EMIT,
		DP_MEASURED
	} dp_op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_OP1,
		C_RAMP_OFF,
		C_DIV_BUSY,
		C_NO_WAIT,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		dp_op_t op;
		cond_t cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic op;
		logic ramp_off;
		logic div_busy;
		logic no_wait;
		logic out_busy;
	} dp_status_t;

	function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_word_t cw;
		cw = '{op: DP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
		unique case (pc)
			STEP_IDLE: cw = '{op: DP_ACCEPT, cond: C_NO_INPUT, target: STEP_IDLE};
			STEP_DISPATCH: cw = '{op: DP_NOP, cond: C_OP1, target: STEP_MEASURED};
			STEP_RAMP: cw = '{op: DP_RAMP, cond: C_RAMP_OFF, target: STEP_DIV_STEADY};
			STEP_MUL: cw = '{op: DP_MUL, cond: C_NEVER, target: STEP_IDLE};
			STEP_DIV_RAMP: cw = '{op: DP_DIV_RAMP, cond: C_NEVER, target: STEP_IDLE};
			STEP_WAIT_RAMP: cw = '{op: DP_NOP, cond: C_DIV_BUSY, target: STEP_WAIT_RAMP};
			STEP_DIV_GAP: cw = '{op: DP_DIV_GAP, cond: C_NEVER, target: STEP_IDLE};
			STEP_WAIT_GAP: cw = '{op: DP_NOP, cond: C_DIV_BUSY, target: STEP_WAIT_GAP};
			STEP_TO_DECIDE: cw = '{op: DP_NOP, cond: C_ALWAYS, target: STEP_DECIDE};
			STEP_DIV_STEADY: cw = '{op: DP_DIV_STEADY, cond: C_NEVER, target: STEP_IDLE};
			STEP_WAIT_STEADY: cw = '{op: DP_NOP, cond: C_DIV_BUSY, target: STEP_WAIT_STEADY};
			STEP_DECIDE: cw = '{op: DP_DECIDE, cond: C_NO_WAIT, target: STEP_IDLE};
			STEP_EMIT: cw = '{op: DP_EMIT, cond: C_OUT_BUSY, target: STEP_EMIT};
			STEP_EMIT_DONE: cw = '{op: DP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
			STEP_MEASURED: cw = '{op: DP_MEASURED, cond: C_ALWAYS, target: STEP_IDLE};
			default: cw = '{op: DP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

// ----- design/msgp_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module msgp_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [msgp_pkg::DIV_REM_W-1:0] rem_init,
	input wire logic [msgp_pkg::WAIT_W-1:0] num,
	input wire logic [msgp_pkg::DIV_REM_W-1:0] den,
	output logic busy,
	output logic [msgp_pkg::WAIT_W-1:0] quot
);

	logic busy_q;
	logic [msgp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [msgp_pkg::DIV_REM_W-1:0] rem_q;
	logic [msgp_pkg::DIV_REM_W-1:0] den_q;
	logic [msgp_pkg::WAIT_W-1:0] num_q;
	logic [msgp_pkg::DIV_REM_W:0] part;
	logic [msgp_pkg::DIV_REM_W:0] den_x;
	logic ge;

	assign part = {rem_q, num_q[msgp_pkg::WAIT_W-1]};
	assign den_x = {1'b0, den_q};
	assign ge = part >= den_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= msgp_pkg::DIV_CNT_W'(msgp_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == msgp_pkg::DIV_CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? msgp_pkg::DIV_REM_W'(part - den_x) : part[msgp_pkg::DIV_REM_W-1:0];
			num_q <= {num_q[msgp_pkg::WAIT_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = num_q;

endmodule

`default_nettype wire

// ----- design/msgp_seq.sv -----
// Microcode sequencer: step counter, control ROM fetch and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module msgp_seq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire msgp_pkg::dp_status_t status,
	output msgp_pkg::ctrl_word_t ctrl,
	output logic in_stall
);

	logic [msgp_pkg::PC_W-1:0] pc_q;
	msgp_pkg::ctrl_word_t cw;
	logic take;

	assign cw = msgp_pkg::ucode_rom(pc_q);

	always_comb begin
		unique case (cw.cond)
			msgp_pkg::C_NEVER: take = 1'b0;
			msgp_pkg::C_ALWAYS: take = 1'b1;
			msgp_pkg::C_NO_INPUT: take = !in_valid;
			msgp_pkg::C_OP1: take = status.op;
			msgp_pkg::C_RAMP_OFF: take = status.ramp_off;
			msgp_pkg::C_DIV_BUSY: take = status.div_busy;
			msgp_pkg::C_NO_WAIT: take = status.no_wait;
			msgp_pkg::C_OUT_BUSY: take = status.out_busy;
			default: take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= msgp_pkg::STEP_IDLE;
		else if (take)
			pc_q <= cw.target;
		else
			pc_q <= pc_q + 1'b1;
	end

	assign ctrl = cw;
	assign in_stall = pc_q != msgp_pkg::STEP_IDLE;

endmodule

`default_nettype wire

// ----- design/msgp_dp.sv -----
// Pacer datapath: configuration, pacing state, multiplier, divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module msgp_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire msgp_pkg::ctrl_word_t ctrl,
	output msgp_pkg::dp_status_t status,
	input wire logic cfg_we,
	input wire logic [msgp_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [msgp_pkg::RATE_W-1:0] cfg_data,
	input wire logic in_valid,
	input wire logic op,
	input wire logic [msgp_pkg::TIME_W-1:0] proc_time_us,
	input wire logic [msgp_pkg::TIME_W-1:0] now_seconds,
	input wire logic [msgp_pkg::TIME_W-1:0] actual_wait_us,
	output logic out_valid,
	input wire logic out_stall,
	output logic [msgp_pkg::WAIT_W-1:0] wait_us
);

	logic [msgp_pkg::RATE_W-1:0] rate_q;
	logic [msgp_pkg::RAMP_W-1:0] ramp_q;
	logic active_q;
	logic started_q;
	logic [msgp_pkg::TIME_W-1:0] start_q;
	logic signed [31:0] os_q;
	logic [msgp_pkg::WAIT_W-1:0] last_wait_q;
	logic out_valid_q;

	logic op_q;
	logic [msgp_pkg::TIME_W-1:0] proc_q;
	logic [msgp_pkg::TIME_W-1:0] now_q;
	logic [msgp_pkg::TIME_W-1:0] act_q;
	logic [msgp_pkg::PROD_W-1:0] prod_q;
	logic [msgp_pkg::WAIT_W-1:0] wait_q;
	logic [msgp_pkg::WAIT_W-1:0] wait_out_q;

	logic [msgp_pkg::RATE_W-1:0] rate_eff;
	logic [msgp_pkg::RATE_W-1:0] rate_m1;
	logic [msgp_pkg::TIME_W-1:0] eff_start;
	logic [msgp_pkg::TIME_W:0] end_sum;
	logic ramp_end;
	logic ramp_off;
	logic [msgp_pkg::TIME_W-1:0] elapsed;
	logic out_busy;

	logic div_start;
	logic div_busy;
	logic [msgp_pkg::DIV_REM_W-1:0] div_rem;
	logic [msgp_pkg::WAIT_W-1:0] div_num;
	logic [msgp_pkg::DIV_REM_W-1:0] div_den;
	logic [msgp_pkg::WAIT_W-1:0] quot;

	logic signed [34:0] gap_x;
	logic signed [34:0] proc_x;
	logic signed [34:0] os_x;
	logic signed [34:0] diff_s;
	logic signed [34:0] meas_s;
	logic signed [34:0] usec_x;
	logic [msgp_pkg::WAIT_W-1:0] wait_sat;
	logic new_active;

	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		logic [31:0] r;
		if (v > 35'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -35'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	assign rate_eff = (rate_q == '0) ? msgp_pkg::RATE_W'(1) : rate_q;
	assign rate_m1 = rate_eff - 1'b1;
	assign eff_start = started_q ? start_q : now_q;
	assign end_sum = {1'b0, eff_start} + {17'd0, ramp_q};
	assign ramp_end = end_sum < {1'b0, now_q};
	assign ramp_off = !active_q || (ramp_q == '0) || ramp_end;
	assign elapsed = (now_q >= start_q) ? (now_q - start_q) : '0;
	assign out_busy = out_valid_q && out_stall;

	assign gap_x = $signed({15'd0, quot});
	assign proc_x = $signed({3'd0, proc_q});
	assign os_x = {{3{os_q[31]}}, os_q};
	assign diff_s = gap_x - proc_x - os_x;
	assign meas_s = $signed({3'd0, act_q}) - $signed({15'd0, last_wait_q});
	assign usec_x = $signed({15'd0, msgp_pkg::USEC_PER_SEC});
	assign wait_sat = (diff_s > usec_x) ? msgp_pkg::USEC_PER_SEC : diff_s[msgp_pkg::WAIT_W-1:0];
	assign new_active = (cfg_index == msgp_pkg::CFG_RAMP_SECONDS)
		? (cfg_data[msgp_pkg::RAMP_W-1:0] != '0) : (ramp_q != '0);

	always_comb begin
		div_start = 1'b0;
		div_rem = '0;
		div_num = msgp_pkg::USEC_PER_SEC;
		div_den = {1'b0, rate_eff};
		case (ctrl.op)
			msgp_pkg::DP_DIV_RAMP: begin
				div_start = 1'b1;
				div_rem = prod_q[40:20];
				div_num = prod_q[19:0];
				div_den = {5'd0, ramp_q};
			end
			msgp_pkg::DP_DIV_GAP: begin
				div_start = 1'b1;
				div_den = {1'b0, quot} + 21'd1;
			end
			msgp_pkg::DP_DIV_STEADY: begin
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	msgp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.rem_init(div_rem),
		.num(div_num),
		.den(div_den),
		.busy(div_busy),
		.quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 20'd100;
			ramp_q <= '0;
			active_q <= 1'b0;
			started_q <= 1'b0;
			start_q <= '0;
			os_q <= '0;
			last_wait_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && ctrl.op != msgp_pkg::DP_EMIT)
				out_valid_q <= 1'b0;
			case (ctrl.op)
				msgp_pkg::DP_RAMP: begin
					if (active_q) begin
						started_q <= 1'b1;
						start_q <= eff_start;
						if (ramp_off)
							active_q <= 1'b0;
					end
				end
				msgp_pkg::DP_DECIDE: begin
					if (diff_s <= 35'sd0)
						os_q <= sat32(-diff_s);
				end
				msgp_pkg::DP_EMIT: begin
					if (!out_busy) begin
						out_valid_q <= 1'b1;
						last_wait_q <= wait_q;
					end
				end
				msgp_pkg::DP_MEASURED: begin
					os_q <= sat32(meas_s);
				end
				default: begin
				end
			endcase
			if (cfg_we) begin
				if (cfg_index == msgp_pkg::CFG_TARGET_RATE)
					rate_q <= cfg_data;
				else
					ramp_q <= cfg_data[msgp_pkg::RAMP_W-1:0];
				active_q <= new_active;
				started_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == msgp_pkg::DP_ACCEPT && in_valid) begin
			op_q <= op;
			proc_q <= proc_time_us;
			now_q <= now_seconds;
			act_q <= actual_wait_us;
		end
		if (ctrl.op == msgp_pkg::DP_MUL)
			prod_q <= {32'd0, rate_m1} * {20'd0, elapsed};
		if (ctrl.op == msgp_pkg::DP_DECIDE && diff_s > 35'sd0)
			wait_q <= wait_sat;
		if (ctrl.op == msgp_pkg::DP_EMIT && !out_busy)
			wait_out_q <= wait_q;
	end

	assign status = '{op: op_q, ramp_off: ramp_off, div_busy: div_busy,
		no_wait: (diff_s <= 35'sd0), out_busy: out_busy};

	assign out_valid = out_valid_q;
	assign wait_us = wait_out_q;

	a_wait_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (wait_us != '0) && (wait_us <= msgp_pkg::USEC_PER_SEC))
		else $error("emitted wait out of range");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_start_latch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(started_q) |-> $past(ctrl.op == msgp_pkg::DP_RAMP))
		else $error("ramp start latched outside ramp step");

	a_emit_sets_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> last_wait_q == wait_out_q)
		else $error("last wait does not match emitted beat");

endmodule

`default_nettype wire

// ----- design/message_pacer_slow_start.sv -----
// Top level of the message pacer with linear slow start.
// One item is taken at a time; in_stall is low only while the sequencer sits in its idle
// step. A measured-wait report uses no divider. A message report uses the shared divider,
// which produces one quotient bit per cycle over 20 steps and holds the sequencer while it
// is busy; it runs once per message (twice during slow start, after one 20x32 multiply).
// A message report that yields a wait then passes through the emit step. A result waits
// in an output register; if it is still stalled when the next result is ready, the
// sequencer holds at its emit step for as long as the stall lasts. Configuration writes
// are taken at any cycle.
`timescale 1ns / 1ps
`default_nettype none

module message_pacer_slow_start (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [msgp_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [msgp_pkg::RATE_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic op,
	input wire logic [msgp_pkg::TIME_W-1:0] proc_time_us,
	input wire logic [msgp_pkg::TIME_W-1:0] now_seconds,
	input wire logic [msgp_pkg::TIME_W-1:0] actual_wait_us,
	output logic out_valid,
	input wire logic out_stall,
	output logic [msgp_pkg::WAIT_W-1:0] wait_us
);

	msgp_pkg::ctrl_word_t ctrl;
	msgp_pkg::dp_status_t status;

	msgp_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.status(status),
		.ctrl(ctrl),
		.in_stall(in_stall)
	);

	msgp_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.op(op),
		.proc_time_us(proc_time_us),
		.now_seconds(now_seconds),
		.actual_wait_us(actual_wait_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.wait_us(wait_us)
	);

endmodule

`default_nettype wire

// ----- tb/tb_message_pacer_slow_start.sv -----
// Self-checking pacer testbench: directed reset, rate, slow start cases, then paced random traffic.
`timescale 1ns / 1ps

module tb_message_pacer_slow_start;

	localparam logic OP_SENT = 1'b0;
	localparam logic OP_MEASURED = 1'b1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 100;
	localparam longint WAIT_CAP = 1000000;
	localparam int SEG_ITEMS = 85;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [msgp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [msgp_pkg::RATE_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic op;
	logic [msgp_pkg::TIME_W-1:0] proc_time_us;
	logic [msgp_pkg::TIME_W-1:0] now_seconds;
	logic [msgp_pkg::TIME_W-1:0] actual_wait_us;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [msgp_pkg::WAIT_W-1:0] wait_us;

	// pacer state as predicted
	logic [msgp_pkg::RATE_W-1:0] pace_rate;
	logic [msgp_pkg::RAMP_W-1:0] pace_ramp;
	logic ramp_live;
	logic ramp_latched;
	logic [msgp_pkg::TIME_W-1:0] ramp_origin;
	logic [msgp_pkg::WAIT_W-1:0] gap_cur;
	int overshoot;
	logic [msgp_pkg::WAIT_W-1:0] last_wait;

	logic [msgp_pkg::WAIT_W-1:0] pending_waits[$];
	logic [msgp_pkg::WAIT_W-1:0] want_wait;
	int fail_cnt = 0;
	int cycle_cnt = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic [msgp_pkg::TIME_W-1:0] clock_s = '0;

	message_pacer_slow_start u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.proc_time_us(proc_time_us),
		.now_seconds(now_seconds),
		.actual_wait_us(actual_wait_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.wait_us(wait_us)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_message_pacer_slow_start failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_waits.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected beat: wait_us actual %0d", wait_us);
			end else begin
				want_wait = pending_waits.pop_front();
				if (wait_us !== want_wait) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("mismatch: wait_us expected %0d actual %0d", want_wait, wait_us);
				end
			end
		end
	end

	function automatic int clamp32(input longint v);
		if (v > longint'(32'sh7FFFFFFF))
			return 32'sh7FFFFFFF;
		if (v < -longint'(64'h80000000))
			return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic logic [msgp_pkg::WAIT_W-1:0] steady_gap();
		longint unsigned rate;
		rate = (pace_rate == '0) ? 64'd1 : 64'(pace_rate);
		return msgp_pkg::WAIT_W'(64'd1000000 / rate);
	endfunction

	task automatic apply_reg_write(input logic [msgp_pkg::CFG_IDX_W-1:0] idx,
			input logic [msgp_pkg::RATE_W-1:0] data);
		if (idx == msgp_pkg::CFG_TARGET_RATE)
			pace_rate = data;
		else
			pace_ramp = data[msgp_pkg::RAMP_W-1:0];
		gap_cur = steady_gap();
		ramp_live = (pace_ramp != '0);
		ramp_latched = 1'b0;
	endtask

	task automatic pace_message(input logic [msgp_pkg::TIME_W-1:0] proc,
			input logic [msgp_pkg::TIME_W-1:0] now);
		longint unsigned rate;
		longint unsigned elapsed;
		longint unsigned div;
		longint g;
		longint p;
		longint o;
		longint w;
		rate = (pace_rate == '0) ? 64'd1 : 64'(pace_rate);
		if (ramp_live) begin
			if (!ramp_latched) begin
				ramp_latched = 1'b1;
				ramp_origin = now;
			end
			if (pace_ramp == '0 || 64'(ramp_origin) + 64'(pace_ramp) < 64'(now)) begin
				ramp_live = 1'b0;
				gap_cur = steady_gap();
			end else begin
				elapsed = (now >= ramp_origin) ? 64'(now - ramp_origin) : 64'd0;
				div = 64'd1 + ((rate - 64'd1) * elapsed) / 64'(pace_ramp);
				gap_cur = msgp_pkg::WAIT_W'(64'd1000000 / div);
			end
		end
		g = 64'(gap_cur);
		p = 64'(proc);
		o = overshoot;
		if (g > p + o) begin
			w = g - p - o;
			if (w > WAIT_CAP)
				w = WAIT_CAP;
			last_wait = msgp_pkg::WAIT_W'(w);
			pending_waits.push_back(last_wait);
		end else begin
			overshoot = clamp32(o - g + p);
		end
	endtask

	task automatic record_measured_wait(input logic [msgp_pkg::TIME_W-1:0] act);
		longint a;
		longint l;
		a = 64'(act);
		l = 64'(last_wait);
		overshoot = clamp32(a - l);
	endtask

	task automatic send_item(input logic kind, input logic [msgp_pkg::TIME_W-1:0] proc,
			input logic [msgp_pkg::TIME_W-1:0] now, input logic [msgp_pkg::TIME_W-1:0] act);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op = kind;
		proc_time_us = proc;
		now_seconds = now;
		actual_wait_us = act;
		do
			@(posedge clk);
		while (in_stall);
		if (kind == OP_SENT)
			pace_message(proc, now);
		else
			record_measured_wait(act);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_waits.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [msgp_pkg::CFG_IDX_W-1:0] idx,
			input logic [msgp_pkg::RATE_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_data = ~data;
		apply_reg_write(idx, data);
	endtask

	task automatic test_reset_state();
		send_item(OP_SENT, 32'd0, 32'd0, $urandom);
		send_item(OP_MEASURED, $urandom, $urandom, 32'd0);
		send_item(OP_SENT, 32'd0, 32'd5, $urandom);
		send_item(OP_MEASURED, $urandom, $urandom, 32'hFFFFFFFF);
		send_item(OP_SENT, 32'hFFFFFFFF, 32'hFFFFFFFF, $urandom);
		send_item(OP_MEASURED, $urandom, $urandom, 32'd20000);
		wait_idle();
	endtask

	task automatic test_rate_extremes();
		write_reg(msgp_pkg::CFG_TARGET_RATE, 20'd0);
		send_item(OP_SENT, 32'd0, 32'd7, $urandom);
		send_item(OP_MEASURED, $urandom, $urandom, 32'd0);
		send_item(OP_SENT, 32'd0, 32'd8, $urandom);
		wait_idle();
		write_reg(msgp_pkg::CFG_TARGET_RATE, 20'hFFFFF);
		send_item(OP_SENT, 32'd0, 32'd9, $urandom);
		send_item(OP_MEASURED, $urandom, $urandom, 32'd1000000);
		send_item(OP_SENT, 32'd0, 32'd10, $urandom);
		wait_idle();
		write_reg(msgp_pkg::CFG_TARGET_RATE, 20'd1000000);
		send_item(OP_SENT, 32'd0, 32'd11, $urandom);
		wait_idle();
	endtask

	task automatic test_slow_start();
		write_reg(msgp_pkg::CFG_TARGET_RATE, 20'd10);
		write_reg(msgp_pkg::CFG_RAMP_SECONDS, 20'hF0004);
		send_item(OP_SENT, 32'd0, 32'd100, $urandom);
		send_item(OP_MEASURED, $urandom, $urandom, 32'd1000000);
		send_item(OP_SENT, 32'd0, 32'd102, $urandom);
		send_item(OP_SENT, 32'd0, 32'd99, $urandom);
		send_item(OP_SENT, 32'd0, 32'd104, $urandom);
		send_item(OP_SENT, 32'd0, 32'd105, $urandom);
		wait_idle();
		write_reg(msgp_pkg::CFG_TARGET_RATE, 20'd10);
		send_item(OP_SENT, 32'd0, 32'hFFFFFFFF, $urandom);
		wait_idle();
		write_reg(msgp_pkg::CFG_TARGET_RATE, 20'd1000000);
		write_reg(msgp_pkg::CFG_RAMP_SECONDS, 20'd65535);
		send_item(OP_SENT, 32'd0, 32'd0, $urandom);
		send_item(OP_SENT, 32'd0, 32'd65535, $urandom);
		send_item(OP_SENT, 32'd0, 32'd65536, $urandom);
		wait_idle();
		write_reg(msgp_pkg::CFG_RAMP_SECONDS, 20'd0);
	endtask

	function automatic logic [msgp_pkg::RATE_W-1:0] pick_rate();
		case ($urandom_range(9))
			0: return 20'd0;
			1: return 20'd1;
			2: return 20'd1000000;
			3: return 20'hFFFFF;
			4: return msgp_pkg::RATE_W'($urandom);
			default: return msgp_pkg::RATE_W'($urandom_range(1, 3000));
		endcase
	endfunction

	function automatic logic [msgp_pkg::RAMP_W-1:0] pick_ramp();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return msgp_pkg::RAMP_W'($urandom);
			default: return msgp_pkg::RAMP_W'($urandom_range(1, 8));
		endcase
	endfunction

	task automatic reconfigure();
		int sel;
		sel = $urandom_range(2);
		wait_idle();
		if (sel != 1)
			write_reg(msgp_pkg::CFG_TARGET_RATE, pick_rate());
		if (sel != 0)
			write_reg(msgp_pkg::CFG_RAMP_SECONDS, {4'($urandom), pick_ramp()});
		if ($urandom_range(3) == 0)
			clock_s = $urandom;
	endtask

	task automatic send_paced_message();
		logic [msgp_pkg::TIME_W-1:0] proc;
		int r;
		r = $urandom_range(19);
		if (r == 0)
			clock_s = clock_s - $urandom_range(1, 3);
		else if (r == 1)
			clock_s = $urandom;
		else
			clock_s = clock_s + $urandom_range(0, 2);
		case ($urandom_range(9))
			0: proc = $urandom;
			1: proc = 32'(gap_cur) + $urandom_range(0, 100);
			default: proc = $urandom_range(0, gap_cur / 2);
		endcase
		send_item(OP_SENT, proc, clock_s, $urandom);
	endtask

	task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
		int sent;
		logic [msgp_pkg::TIME_W-1:0] act;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < items) begin
			if (sent % SEG_ITEMS == 0)
				reconfigure();
			if ($urandom_range(9) == 0) begin
				send_item(1'($urandom_range(1)), $urandom, $urandom, $urandom);
				sent++;
			end else begin
				send_paced_message();
				sent++;
				if ($urandom_range(1) == 0) begin
					if ($urandom_range(3) == 0)
						act = 32'(last_wait) - $urandom_range(0, last_wait);
					else
						act = 32'(last_wait) + $urandom_range(0, 300);
					send_item(OP_MEASURED, $urandom, $urandom, act);
					sent++;
				end
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_SENT;
		proc_time_us = '0;
		now_seconds = '0;
		actual_wait_us = '0;
		pace_rate = 20'd100;
		pace_ramp = '0;
		ramp_origin = '0;
		overshoot = 0;
		last_wait = '0;
		gap_cur = steady_gap();
		ramp_live = 1'b0;
		ramp_latched = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_state();
		test_rate_extremes();
		test_slow_start();
		test_random_traffic(425, 0, 0);
		test_random_traffic(425, 60, 0);
		test_random_traffic(425, 0, 60);
		test_random_traffic(425, 27, 27);
		if (fail_cnt == 0)
			$display("tb_message_pacer_slow_start passed");
		else
			$display("tb_message_pacer_slow_start failed");
		$finish;
	end

endmodule
